FILE: rtl/core/b64c_pkg.sv
// Package for the Base64 stream codec: payload structs, the request bundle
// passed from front to back, character codes and alphabet helpers.
// No dependencies.
package b64c_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int MAX_RES = 4;
    localparam int RIDX_W = $clog2(MAX_RES);
    localparam int RCNT_W = $clog2(MAX_RES + 1);

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_CHAR = 2'd1;
    localparam logic [1:0] ERR_LEN  = 2'd2;

    localparam logic [7:0] CH_PAD = 8'h3D;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_item;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       end_of_run;
        logic [1:0] error_code;
    } t_out;

    // Results caused by one accepted request.
    typedef struct packed {
        logic [RCNT_W-1:0]          cnt;
        logic [MAX_RES-1:0][7:0]    data;
        logic                       stat_only;
        logic                       last;
        logic [1:0]                 err;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sext;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'(8'h41 + {2'b00, v});
        end else if (v < 6'd52) begin
            c = 8'(8'h61 + {2'b00, v} - 8'd26);
        end else if (v < 6'd62) begin
            c = 8'(8'h30 + {2'b00, v} - 8'd52);
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic t_sext dec_char(input logic [7:0] c);
        t_sext s;
        s = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.ok  = 1'b1;
            s.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.ok  = 1'b1;
            s.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.ok  = 1'b1;
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.ok  = 1'b1;
            s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.ok  = 1'b1;
            s.val = 6'd63;
        end
        return s;
    endfunction

endpackage

FILE: rtl/core/b64c_front.sv
// Front end: accepts requests, runs the encode/decode state update and
// builds the result bundle for each request. Depends on b64c_pkg.
module b64c_front import b64c_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in     i_in,
    input  logic    i_cfg_valid,
    input  logic    i_cfg_data,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_bundle o_bundle
);

    logic       r_dir;
    logic [1:0] r_grp;
    logic [5:0] r_held;
    logic [2:0] r_pend;
    logic [1:0] r_pos;
    logic [1:0] r_trim;
    logic       r_pad;
    logic       r_err;

    logic [1:0] n_grp;
    logic [5:0] n_held;
    logic [2:0] n_pend;
    logic [1:0] n_pos;
    logic [1:0] n_trim;
    logic       n_pad;
    logic       n_err;

    logic       acc;
    logic       ws;
    t_sext      sx;
    logic [2:0] pend;
    logic [11:0] acc_bits;
    logic [3:0] total;
    t_bundle    bnd;

    assign o_in_ready = !i_q_stat.full;
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        n_grp  = r_grp;
        n_held = r_held;
        n_pend = r_pend;
        n_pos  = r_pos;
        n_trim = r_trim;
        n_pad  = r_pad;
        n_err  = r_err;
        bnd    = '0;
        ws     = (i_in.data_byte == CH_CR) || (i_in.data_byte == CH_LF)
              || (i_in.data_byte == CH_SP);
        sx     = dec_char(i_in.data_byte);
        pend   = (r_pend > 3'd6) ? 3'd6 : r_pend;
        acc_bits = {r_held, sx.val};
        total  = 4'({1'b0, pend} + 4'd6);
        if (r_dir == DIR_ENCODE) begin
            unique case (r_grp)
                2'd0: begin
                    bnd.data[0] = enc_char(i_in.data_byte[7:2]);
                    n_held = {4'b0, i_in.data_byte[1:0]};
                    n_grp  = 2'd1;
                    bnd.cnt = RCNT_W'(1);
                    if (i_in.last_item) begin
                        bnd.data[1] = enc_char({i_in.data_byte[1:0], 4'b0});
                        bnd.data[2] = CH_PAD;
                        bnd.data[3] = CH_PAD;
                        bnd.cnt = RCNT_W'(4);
                    end
                end
                2'd1: begin
                    bnd.data[0] = enc_char({r_held[1:0], i_in.data_byte[7:4]});
                    n_held = {2'b0, i_in.data_byte[3:0]};
                    n_grp  = 2'd2;
                    bnd.cnt = RCNT_W'(1);
                    if (i_in.last_item) begin
                        bnd.data[1] = enc_char({i_in.data_byte[3:0], 2'b0});
                        bnd.data[2] = CH_PAD;
                        bnd.cnt = RCNT_W'(3);
                    end
                end
                default: begin
                    bnd.data[0] = enc_char({r_held[3:0], i_in.data_byte[7:6]});
                    bnd.data[1] = enc_char(i_in.data_byte[5:0]);
                    n_held = '0;
                    n_grp  = 2'd0;
                    bnd.cnt = RCNT_W'(2);
                end
            endcase
            bnd.last = i_in.last_item;
        end else begin
            n_pos = 2'(r_pos + 2'd1);
            if (!ws) begin
                n_trim = n_pos;
                if (!r_pad && !r_err) begin
                    if (i_in.data_byte == CH_PAD) begin
                        n_pad = 1'b1;
                    end else if (!sx.ok) begin
                        n_err = 1'b1;
                    end else begin
                        if (total >= 4'd8) begin
                            total = 4'(total - 4'd8);
                            bnd.data[0] = 8'(acc_bits >> total);
                            acc_bits = acc_bits & 12'((12'd1 << total) - 12'd1);
                            bnd.cnt = RCNT_W'(1);
                        end
                        n_held = acc_bits[5:0];
                        n_pend = total[2:0];
                    end
                end
            end
            if (i_in.last_item) begin
                if (bnd.cnt == '0) begin
                    bnd.cnt       = RCNT_W'(1);
                    bnd.stat_only = 1'b1;
                end
                bnd.last = 1'b1;
                bnd.err  = (n_trim == 2'd1) ? ERR_LEN : (n_err ? ERR_CHAR : ERR_OK);
            end
        end
        if (i_in.last_item) begin
            n_grp  = '0;
            n_held = '0;
            n_pend = '0;
            n_pos  = '0;
            n_trim = '0;
            n_pad  = 1'b0;
            n_err  = 1'b0;
        end
    end

    assign o_bundle = bnd;
    assign o_push   = acc && (bnd.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_ENCODE;
            r_grp  <= '0;
            r_held <= '0;
            r_pend <= '0;
            r_pos  <= '0;
            r_trim <= '0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
        end else if (i_cfg_valid) begin
            r_dir  <= i_cfg_data;
            r_grp  <= '0;
            r_held <= '0;
            r_pend <= '0;
            r_pos  <= '0;
            r_trim <= '0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
        end else if (acc) begin
            r_grp  <= n_grp;
            r_held <= n_held;
            r_pend <= n_pend;
            r_pos  <= n_pos;
            r_trim <= n_trim;
            r_pad  <= n_pad;
            r_err  <= n_err;
        end
    end

endmodule

FILE: rtl/core/b64c_queue.sv
// Short bundle queue between front and back ends.
// Depends on b64c_pkg.
module b64c_queue import b64c_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output t_bundle o_head,
    output t_q_stat o_stat
);

    t_bundle             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= QPTR_W'(r_wptr + 1'b1);
            end
            if (i_pop) begin
                r_rptr <= QPTR_W'(r_rptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (i_pop && !i_push) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_stat.full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

    a_cnt_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_cnt == QCNT_W'($past(r_cnt) - 1'b1)))
        else $error("queue count mismatch");

endmodule

FILE: rtl/core/b64c_back.sv
// Back end: walks the results of the head bundle into the output register,
// one per cycle unless the output stalls. Depends on b64c_pkg.
module b64c_back import b64c_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_head,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out
);

    logic [RIDX_W-1:0] r_idx;
    logic              r_ov;
    t_out              r_out;

    logic              load;
    logic              fin;

    assign load  = !i_q_stat.empty && (!r_ov || i_out_ready);
    assign fin   = (RCNT_W'(r_idx) + RCNT_W'(1)) >= i_head.cnt;
    assign o_pop = load && fin;

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte   <= i_head.stat_only ? 8'd0 : i_head.data[r_idx];
            r_out.out_valid  <= !i_head.stat_only;
            r_out.end_of_run <= fin && i_head.last;
            r_out.error_code <= (fin && i_head.last) ? i_head.err : ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= '0;
        end else begin
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (o_pop) begin
                r_idx <= '0;
            end else if (load) begin
                r_idx <= RIDX_W'(r_idx + 1'b1);
            end
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_stat.empty |-> (RCNT_W'(r_idx) < i_head.cnt))
        else $error("result index past bundle");

    a_idx_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_stat.empty |-> (r_idx == '0))
        else $error("result index left over");

    a_err_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.end_of_run) |-> (r_out.error_code == ERR_OK))
        else $error("error code on non-final result");

endmodule

FILE: rtl/core/base64_stream_codec.sv
// Top level of the streaming Base64 codec: front end, bundle queue, back end.
// Depends on b64c_pkg, b64c_front, b64c_queue, b64c_back.
//
// Use:
//   Input requests (i_in: data_byte, last_item) arrive on i_in_valid/o_in_ready.
//   Results (o_out: out_byte, out_valid, end_of_run, error_code) leave on
//   o_out_valid/i_out_ready. The direction register (0 encode, 1 decode) is
//   written on i_cfg_valid/o_cfg_ready; the user must do so while the codec is
//   idle, the block does not enforce it. A write also clears the stream state.
//   A request's results pass through the queue and then the output register
//   before they are shown on o_out.
//   Throughput: one request per cycle while each causes one result and the
//   receiver does not stall; the back end sends one result per cycle, so a
//   three-byte encode group gives four results and a stream's end up to four.
//   Whitespace characters and characters after '=' in decode cause no data result.
//   A two-entry queue between the front and back ends absorbs bursts; when
//   the receiver stalls the output register holds and the queue fills, then
//   o_in_ready drops.
//   Reset (synchronous, active low) selects encode and clears all but the data.
module base64_stream_codec import b64c_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    t_q_stat q_stat;
    t_bundle push_bundle;
    t_bundle head;
    logic    push;
    logic    pop;

    assign o_cfg_ready = 1'b1;

    b64c_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_bundle    (push_bundle)
    );

    b64c_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_stat   (q_stat)
    );

    b64c_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
